/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the checker files of the block.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check while out of reset
`define PBRG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pbrg check failed");

// check on every edge, reset included
`define PBRG_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("pbrg reset check failed");

`endif

/* hw/rtl/pbrg_pkg.sv */
// Types, constants and the arctangent table of the bearing and range block.
// No dependencies.
package pbrg_pkg;

  localparam int POS_W     = 16;
  localparam int OFS_W     = 17;
  localparam int RNG_W     = 17;
  localparam int ANG_W     = 16;
  localparam int CX_W      = 28;
  localparam int Z_W       = 32;
  localparam int SQ_W      = 34;
  localparam int CFG_IDX_W = 2;
  localparam int ATAN_LEN  = 24;
  localparam int ISQRT_STEPS = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_ARRIVE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE  = 2'd1;

  localparam logic [RNG_W-1:0] ARRIVE_RESET = 17'd26;
  localparam logic [RNG_W-1:0] CLOSE_RESET  = 17'd512;

  localparam logic [Z_W-1:0]  HALF_TURN  = 32'h8000_0000;
  localparam logic [Z_W-1:0]  ROUND_HALF = 32'h0000_8000;
  localparam logic [SQ_W-1:0] SQRT_BIT0  = 34'h1_0000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_ITER,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic sq_x;
    logic sq_y;
    logic iter;
  } ctrl_t;

  typedef struct packed {
    logic last;
  } stat_t;

  function automatic logic [Z_W-1:0] atan_entry(input logic [4:0] idx);
    logic [Z_W-1:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/pursuit_bearing_range_guidance.sv */
// Pursuit guidance top level: sequencer, aim-point state, configuration and
// output register. Depends on pbrg_pkg and pbrg_solver.
//
// Usage:
//   Input channel in_*: pursuer pose and target position; a transfer happens
//   when in_valid is high and in_stall low. in_stall is high while an item is
//   in work, so one item is processed at a time.
//   Output channel out_*: one result per item, heading_error and range_out.
//   The result sits in an output register; the next item is accepted while it
//   waits to be taken.
//   Sequence: accept, squaring of dx then of dy, the solver iterations (square
//   root and CORDIC share them), the finish step, then out_valid rises; a new
//   item is taken only after the last one leaves the finish step, as the
//   single shared iteration unit limits throughput.
//   Configuration port cfg_*: index 0 arrive_threshold, index 1 close_range;
//   always ready; to be written between items, which the block does not enforce.
//   Reset: synchronous on rst_n low; clears the aim-point flags, restores the
//   thresholds to 26 and 512 and drops out_valid.
//   Stall: while out_stall holds a waiting result, a finished item waits in
//   the finish step until the output register frees.
module pursuit_bearing_range_guidance #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [pbrg_pkg::POS_W-1:0]    in_pursuer_x,
  input  logic signed [pbrg_pkg::POS_W-1:0]    in_pursuer_y,
  input  logic signed [pbrg_pkg::ANG_W-1:0]    in_pursuer_heading,
  input  logic signed [pbrg_pkg::POS_W-1:0]    in_target_x,
  input  logic signed [pbrg_pkg::POS_W-1:0]    in_target_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [pbrg_pkg::ANG_W-1:0]    out_heading_error,
  output logic [pbrg_pkg::RNG_W-1:0]           out_range_out,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pbrg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pbrg_pkg::RNG_W-1:0]           cfg_data
);

  pbrg_pkg::state_t state_r, state_nxt;
  pbrg_pkg::ctrl_t  ctrl;
  pbrg_pkg::stat_t  stat;

  logic [pbrg_pkg::RNG_W-1:0]        arrive_r, close_r;
  logic [pbrg_pkg::POS_W-1:0]        latched_x_r, latched_y_r;
  logic                              latched_valid_r, point_reached_r;
  logic [pbrg_pkg::ANG_W-1:0]        hd_r;
  logic                              out_valid_r;
  logic [pbrg_pkg::ANG_W-1:0]        err_r;
  logic [pbrg_pkg::RNG_W-1:0]        rng_out_r;

  logic                              accept, fin_fire;
  logic signed [pbrg_pkg::POS_W-1:0] aim_x, aim_y;
  logic signed [pbrg_pkg::OFS_W-1:0] dx, dy;
  logic [pbrg_pkg::RNG_W-1:0]        rng;
  logic [pbrg_pkg::ANG_W-1:0]        bearing;
  logic [pbrg_pkg::RNG_W-1:0]        rng_sel;

  assign in_stall  = (state_r != pbrg_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign fin_fire  = (state_r == pbrg_pkg::ST_FIN) && (!out_valid_r || !out_stall);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pbrg_pkg::ST_IDLE: if (in_valid) state_nxt = pbrg_pkg::ST_SQX;
      pbrg_pkg::ST_SQX:  state_nxt = pbrg_pkg::ST_SQY;
      pbrg_pkg::ST_SQY:  state_nxt = pbrg_pkg::ST_ITER;
      pbrg_pkg::ST_ITER: if (stat.last) state_nxt = pbrg_pkg::ST_FIN;
      pbrg_pkg::ST_FIN:  if (!out_valid_r || !out_stall) state_nxt = pbrg_pkg::ST_IDLE;
      default:           state_nxt = pbrg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state_r)
      pbrg_pkg::ST_IDLE: ctrl.load = in_valid;
      pbrg_pkg::ST_SQX:  ctrl.sq_x = 1'b1;
      pbrg_pkg::ST_SQY:  ctrl.sq_y = 1'b1;
      pbrg_pkg::ST_ITER: ctrl.iter = 1'b1;
      pbrg_pkg::ST_FIN:  ctrl = '0;
      default:           ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pbrg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arrive_r <= pbrg_pkg::ARRIVE_RESET;
      close_r  <= pbrg_pkg::CLOSE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pbrg_pkg::CFG_ARRIVE: arrive_r <= cfg_data;
        pbrg_pkg::CFG_CLOSE:  close_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // aim at the latched point until it is reached, the live target after that
  assign aim_x = (point_reached_r || !latched_valid_r) ? in_target_x : latched_x_r;
  assign aim_y = (point_reached_r || !latched_valid_r) ? in_target_y : latched_y_r;
  assign dx = {aim_x[pbrg_pkg::POS_W-1], aim_x}
            - {in_pursuer_x[pbrg_pkg::POS_W-1], in_pursuer_x};
  assign dy = {aim_y[pbrg_pkg::POS_W-1], aim_y}
            - {in_pursuer_y[pbrg_pkg::POS_W-1], in_pursuer_y};

  pbrg_solver #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_solver (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .dx_i      (dx),
    .dy_i      (dy),
    .stat      (stat),
    .range_o   (rng),
    .bearing_o (bearing)
  );

  assign rng_sel = !point_reached_r ? rng : ((rng < close_r) ? rng : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latched_valid_r <= 1'b0;
      point_reached_r <= 1'b0;
      latched_x_r     <= '0;
      latched_y_r     <= '0;
    end else begin
      if (accept && !latched_valid_r) begin
        latched_x_r     <= in_target_x;
        latched_y_r     <= in_target_y;
        latched_valid_r <= 1'b1;
      end
      if (fin_fire && !point_reached_r && (rng < arrive_r)) begin
        point_reached_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hd_r <= in_pursuer_heading;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      err_r     <= bearing - hd_r;
      rng_out_r <= rng_sel;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_heading_error = err_r;
  assign out_range_out     = rng_out_r;

endmodule

/* hw/rtl/pbrg_solver.sv */
// Iterative range and bearing unit: shared squarer, bit-serial square root
// and CORDIC vectoring stepped by the top-level sequencer. Uses pbrg_pkg.
module pbrg_solver #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pbrg_pkg::ctrl_t                    ctrl,
  input  logic signed [pbrg_pkg::OFS_W-1:0]  dx_i,
  input  logic signed [pbrg_pkg::OFS_W-1:0]  dy_i,
  output pbrg_pkg::stat_t                    stat,
  output logic [pbrg_pkg::RNG_W-1:0]         range_o,
  output logic [pbrg_pkg::ANG_W-1:0]         bearing_o
);

  localparam int STEPS_EFF = (CORDIC_STEPS > pbrg_pkg::ATAN_LEN) ? pbrg_pkg::ATAN_LEN
                                                                  : CORDIC_STEPS;
  localparam int ITER_N = (STEPS_EFF > pbrg_pkg::ISQRT_STEPS) ? STEPS_EFF
                                                              : pbrg_pkg::ISQRT_STEPS;
  localparam int CNT_W = $clog2(ITER_N);

  logic signed [pbrg_pkg::OFS_W-1:0] dx_r, dy_r;
  logic                              zero_r;
  logic signed [pbrg_pkg::CX_W-1:0]  x_r, y_r;
  logic [pbrg_pkg::Z_W-1:0]          z_r;
  logic [pbrg_pkg::SQ_W-1:0]         n_r, res_r, bit_r;
  logic [CNT_W-1:0]                  cnt_r;

  logic signed [pbrg_pkg::OFS_W-1:0] mul_a;
  logic [pbrg_pkg::POS_W-1:0]        mul_abs;
  logic [2*pbrg_pkg::POS_W-1:0]      mul_op, prod;
  logic [pbrg_pkg::SQ_W-1:0]         sq_v;
  logic signed [pbrg_pkg::CX_W-1:0]  x_ld, y_ld, xs, ys;
  logic [pbrg_pkg::SQ_W-1:0]         trial;
  logic [pbrg_pkg::Z_W-1:0]          atan_v, z_rnd;

  assign mul_a   = ctrl.sq_y ? dy_r : dx_r;
  assign mul_abs = mul_a[pbrg_pkg::OFS_W-1] ? 16'(-mul_a) : 16'(mul_a);
  assign mul_op  = {{pbrg_pkg::POS_W{1'b0}}, mul_abs};
  assign prod    = mul_op * mul_op;
  assign sq_v    = {{(pbrg_pkg::SQ_W-2*pbrg_pkg::POS_W){1'b0}}, prod};

  assign x_ld = {{(pbrg_pkg::CX_W-pbrg_pkg::OFS_W-8){dx_i[pbrg_pkg::OFS_W-1]}}, dx_i, 8'h00};
  assign y_ld = {{(pbrg_pkg::CX_W-pbrg_pkg::OFS_W-8){dy_i[pbrg_pkg::OFS_W-1]}}, dy_i, 8'h00};

  assign xs     = x_r >>> cnt_r;
  assign ys     = y_r >>> cnt_r;
  assign atan_v = pbrg_pkg::atan_entry(5'(cnt_r));
  assign trial  = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctrl.load) begin
      cnt_r <= '0;
    end else if (ctrl.iter) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      dx_r   <= dx_i;
      dy_r   <= dy_i;
      zero_r <= (dx_i == '0) && (dy_i == '0);
      x_r    <= dx_i[pbrg_pkg::OFS_W-1] ? -x_ld : x_ld;
      y_r    <= dx_i[pbrg_pkg::OFS_W-1] ? -y_ld : y_ld;
      z_r    <= dx_i[pbrg_pkg::OFS_W-1] ? pbrg_pkg::HALF_TURN : '0;
      res_r  <= '0;
      bit_r  <= pbrg_pkg::SQRT_BIT0;
    end else if (ctrl.sq_x) begin
      n_r <= sq_v;
    end else if (ctrl.sq_y) begin
      n_r <= n_r + sq_v;
    end else if (ctrl.iter) begin
      if (cnt_r < CNT_W'(STEPS_EFF)) begin
        if (!y_r[pbrg_pkg::CX_W-1]) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + atan_v;
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - atan_v;
        end
      end
      if (bit_r != '0) begin
        if (n_r >= trial) begin
          n_r   <= n_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
    end
  end

  assign z_rnd     = z_r + pbrg_pkg::ROUND_HALF;
  assign bearing_o = zero_r ? '0 : z_rnd[pbrg_pkg::Z_W-1:pbrg_pkg::Z_W-pbrg_pkg::ANG_W];
  assign range_o   = res_r[pbrg_pkg::RNG_W-1:0];
  assign stat.last = (cnt_r == CNT_W'(ITER_N - 1));

endmodule

/* hw/rtl/pbrg_checker.sv */
// Port-level checks of the guidance block, bound to its top level.
// Depends on assert_macros.svh and pbrg_pkg.
`include "assert_macros.svh"

module pbrg_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [pbrg_pkg::RNG_W-1:0]     out_range_out,
  input logic                           cfg_valid,
  input logic                           cfg_ready
);

  // an accepted item keeps the input side busy in the next cycle
  `PBRG_ASSERT(a_busy_after_transfer, (in_valid && !in_stall) |=> in_stall)

  // a waiting result stays put under stall
  `PBRG_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_range_out)))

  // with no result waiting, an accepted item brings none out during its squaring steps
  `PBRG_ASSERT(a_min_latency, (in_valid && !in_stall && !out_valid) |=> ##1 !out_valid)

  // reset drops the result register
  `PBRG_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid)

  // configuration writes are never refused
  `PBRG_ASSERT(a_cfg_ready, cfg_valid |-> cfg_ready)

endmodule

bind pursuit_bearing_range_guidance pbrg_checker u_pbrg_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_range_out (out_range_out),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready)
);

/* sim/pursuit_bearing_range_guidance_test.sv */
// Self-checking testbench for the pursuit bearing and range guidance block.
// Predicts heading error and range per pose with a bit-exact CORDIC and square root.
// Depends on pbrg_pkg and pursuit_bearing_range_guidance.
module pursuit_bearing_range_guidance_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS       = 16;
  localparam int SETTLE      = 30;
  localparam int CYCLE_LIMIT = 300000;
  localparam int POS_W       = pbrg_pkg::POS_W;
  localparam int ANG_W       = pbrg_pkg::ANG_W;
  localparam int RNG_W       = pbrg_pkg::RNG_W;
  localparam logic [pbrg_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [pbrg_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [ANG_W-1:0] hd;
    logic signed [POS_W-1:0] tx;
    logic signed [POS_W-1:0] ty;
  } pose_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] err;
    logic [RNG_W-1:0]        rng;
  } steer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [POS_W-1:0] in_pursuer_x = '0;
  logic signed [POS_W-1:0] in_pursuer_y = '0;
  logic signed [ANG_W-1:0] in_pursuer_heading = '0;
  logic signed [POS_W-1:0] in_target_x = '0;
  logic signed [POS_W-1:0] in_target_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [ANG_W-1:0] out_heading_error;
  logic [RNG_W-1:0] out_range_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [pbrg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [RNG_W-1:0] cfg_data = '0;

  steer_t expected_steer[$];
  logic signed [POS_W-1:0] aim_lx = '0;
  logic signed [POS_W-1:0] aim_ly = '0;
  bit aim_latched = 1'b0;
  bit aim_reached = 1'b0;
  logic [RNG_W-1:0] arrive_thr = pbrg_pkg::ARRIVE_RESET;
  logic [RNG_W-1:0] close_thr = pbrg_pkg::CLOSE_RESET;
  bit no_idle = 1'b0;
  int errors = 0;
  int poses_sent = 0;
  int steers_seen = 0;
  int reg_writes = 0;
  int cycles = 0;

  pursuit_bearing_range_guidance #(.CORDIC_STEPS(STEPS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pursuer_x(in_pursuer_x), .in_pursuer_y(in_pursuer_y),
    .in_pursuer_heading(in_pursuer_heading),
    .in_target_x(in_target_x), .in_target_y(in_target_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_heading_error(out_heading_error), .out_range_out(out_range_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("pursuit_bearing_range_guidance test failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= !no_idle && ($urandom_range(0, 99) < 9);
  end

  function automatic logic [31:0] arc_step(int i);
    case (i)
      0:  return 32'd536870912;
      1:  return 32'd316933406;
      2:  return 32'd167458907;
      3:  return 32'd85004756;
      4:  return 32'd42667331;
      5:  return 32'd21354465;
      6:  return 32'd10679838;
      7:  return 32'd5340245;
      8:  return 32'd2670163;
      9:  return 32'd1335087;
      10: return 32'd667544;
      11: return 32'd333772;
      12: return 32'd166886;
      13: return 32'd83443;
      14: return 32'd41722;
      15: return 32'd20861;
      16: return 32'd10430;
      17: return 32'd5215;
      18: return 32'd2608;
      19: return 32'd1304;
      20: return 32'd652;
      21: return 32'd326;
      22: return 32'd163;
      23: return 32'd81;
      default: return '0;
    endcase
  endfunction

  function automatic logic [31:0] floor_root(logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] b;
    rem = n;
    res = '0;
    b = 64'h1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res[31:0];
  endfunction

  function automatic logic [ANG_W-1:0] bearing_of(longint dx, longint dy);
    longint x;
    longint y;
    longint xs;
    longint ys;
    logic [31:0] z;
    logic [31:0] zr;
    int n;
    if (dx == 0 && dy == 0) return '0;
    x = dx * 256;
    y = dy * 256;
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = pbrg_pkg::HALF_TURN;
    end
    n = (STEPS < 24) ? STEPS : 24;
    for (int i = 0; i < n; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + arc_step(i);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - arc_step(i);
      end
    end
    zr = z + pbrg_pkg::ROUND_HALF;
    return zr[31:16];
  endfunction

  function automatic void aim_at(input longint ax, input longint ay, input longint px,
                                 input longint py, input logic [ANG_W-1:0] hd,
                                 output logic [ANG_W-1:0] err, output logic [RNG_W-1:0] rng);
    longint dx;
    longint dy;
    logic [63:0] sq;
    logic [31:0] root;
    dx = ax - px;
    dy = ay - py;
    sq = dx * dx + dy * dy;
    root = floor_root(sq);
    rng = root[RNG_W-1:0];
    err = bearing_of(dx, dy) - hd;
  endfunction

  function automatic steer_t predict_steer(pose_t p);
    steer_t s;
    logic [ANG_W-1:0] e;
    logic [RNG_W-1:0] r;
    if (!aim_latched) begin
      aim_lx = p.tx;
      aim_ly = p.ty;
      aim_latched = 1'b1;
    end
    if (!aim_reached) begin
      aim_at(aim_lx, aim_ly, p.px, p.py, p.hd, e, r);
      if (r < arrive_thr) aim_reached = 1'b1;
    end else begin
      aim_at(p.tx, p.ty, p.px, p.py, p.hd, e, r);
      if (!(r < close_thr)) r = '0;
    end
    s.err = e;
    s.rng = r;
    return s;
  endfunction

  function automatic pose_t make_pose(int px, int py, int hd, int tx, int ty);
    pose_t p;
    p.px = 16'(px);
    p.py = 16'(py);
    p.hd = 16'(hd);
    p.tx = 16'(tx);
    p.ty = 16'(ty);
    return p;
  endfunction

  function automatic pose_t chase_item(logic [RNG_W-1:0] span);
    int lim;
    int px;
    int py;
    if ($urandom_range(0, 99) < 70) begin
      lim = int'(span) + int'(span) / 2 + 4;
      if (lim > 1024) lim = 1024;
      px = int'($urandom_range(0, 63487)) - 31744;
      py = int'($urandom_range(0, 63487)) - 31744;
      return make_pose(px, py, int'($urandom),
                       px + int'($urandom_range(0, 2 * lim)) - lim,
                       py + int'($urandom_range(0, 2 * lim)) - lim);
    end
    return make_pose(int'($urandom), int'($urandom), int'($urandom),
                     int'($urandom), int'($urandom));
  endfunction

  always @(posedge clk) begin : check_steer
    steer_t want;
    if (rst_n && out_valid && !out_stall) begin
      steers_seen++;
      if (expected_steer.size() == 0) begin
        $display("%0t: unexpected result, expected none, got err %0d range %0d",
                 $time, out_heading_error, out_range_out);
        errors++;
      end else begin
        want = expected_steer.pop_front();
        if (out_heading_error !== want.err) begin
          $display("%0t: heading_error expected %0d got %0d",
                   $time, $signed(want.err), out_heading_error);
          errors++;
        end
        if (out_range_out !== want.rng) begin
          $display("%0t: range_out expected %0d got %0d", $time, want.rng, out_range_out);
          errors++;
        end
      end
    end
  end

  task automatic send_pose(pose_t p);
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 99) < 9) repeat ($urandom_range(1, 40)) @(negedge clk);
    in_pursuer_x <= p.px;
    in_pursuer_y <= p.py;
    in_pursuer_heading <= p.hd;
    in_target_x <= p.tx;
    in_target_y <= p.ty;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    expected_steer.push_back(predict_steer(p));
    poses_sent++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic write_reg(logic [pbrg_pkg::CFG_IDX_W-1:0] idx, logic [RNG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == pbrg_pkg::CFG_ARRIVE) arrive_thr = val;
    else if (idx == pbrg_pkg::CFG_CLOSE) close_thr = val;
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (expected_steer.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // first pose latches its target; defaults still in force
  task automatic test_first_latch();
    send_pose(make_pose(-32768, 32767, 32767, 32767, -32768));
    send_pose(make_pose(0, 0, -32768, -1, 1));
    send_pose(make_pose(-1, 1, 0, 12345, -4321));
  endtask

  task automatic test_latched_aim();
    wait_idle();
    write_reg(pbrg_pkg::CFG_ARRIVE, '0);
    send_pose(make_pose(32767, -32768, -32768, 0, 0));
    send_pose(make_pose(32767, -32768, 0, -32768, 32767));
    send_pose(make_pose(32767, 0, 32767, 5, 5));
    send_pose(make_pose(0, -32768, -1, 32767, 32767));
    for (int i = 0; i < 200; i++) begin
      if ($urandom_range(0, 99) < 50)
        send_pose(make_pose(32767 - int'($urandom_range(0, 2000)),
                            -32768 + int'($urandom_range(0, 2000)),
                            int'($urandom), int'($urandom), int'($urandom)));
      else
        send_pose(make_pose(int'($urandom), int'($urandom), int'($urandom),
                            int'($urandom), int'($urandom)));
    end
  endtask

  // approach the latched point; equal range holds off, one less arrives
  task automatic test_arrival();
    wait_idle();
    write_reg(pbrg_pkg::CFG_ARRIVE, 17'd300);
    send_pose(make_pose(32767 - 2000, -32768, 100, 0, 0));
    send_pose(make_pose(32767 - 800, -32768 + 500, -100, 0, 0));
    send_pose(make_pose(32767 - 300, -32768, 0, 0, 0));
    send_pose(make_pose(32767 - 299, -32768, 0, 0, 0));
  endtask

  task automatic test_close_edges();
    send_pose(make_pose(1000, -2000, 0, 1512, -2000));
    send_pose(make_pose(1000, -2000, 0, 1511, -2000));
    send_pose(make_pose(1000, -2000, 16384, 1000, -2511));
    send_pose(make_pose(1000, -2000, -32768, 1000, -2000));
    send_pose(make_pose(32767, 32767, 0, -32768, -32768));
    send_pose(make_pose(-32768, 32767, -32768, 32767, -32768));
  endtask

  task automatic test_chase_sweep(bit write_it, logic [RNG_W-1:0] close_val, int n, bit calm);
    wait_idle();
    if (write_it) write_reg(pbrg_pkg::CFG_CLOSE, close_val);
    no_idle = calm;
    for (int i = 0; i < n; i++) send_pose(chase_item(close_thr));
    no_idle = 1'b0;
  endtask

  // unused indexes and a late arrival threshold must not disturb the chase
  task automatic test_spare_registers();
    wait_idle();
    write_reg(CFG_SPARE_A, 17'($urandom));
    write_reg(CFG_SPARE_B, 17'($urandom));
    write_reg(pbrg_pkg::CFG_ARRIVE, 17'h1FFFF);
    test_chase_sweep(1'b1, 17'd1, 120, 1'b0);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_first_latch();
    test_latched_aim();
    test_arrival();
    test_close_edges();
    test_chase_sweep(1'b0, '0, 120, 1'b1);
    test_chase_sweep(1'b1, '0, 120, 1'b0);
    test_chase_sweep(1'b1, 17'h1FFFF, 120, 1'b0);
    test_chase_sweep(1'b1, 17'($urandom_range(2, 3000)), 120, 1'b0);
    test_spare_registers();
    wait_idle();
    $display("ran %0d poses through latch, arrival and chase with %0d register writes",
             poses_sent, reg_writes);
    $display("checked %0d results, %0d mismatches", steers_seen, errors);
    if (errors == 0) begin
      $display("pursuit_bearing_range_guidance test passed");
    end else begin
      $display("pursuit_bearing_range_guidance test failed");
    end
    $finish;
  end

endmodule
